### rtl/core/sst_pkg.sv
// shared constants, codes and types of the sorted set table
package sst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic eq;
    logic ahead;
  } cmp_res_t;

endpackage

### rtl/core/sst_ram.sv
// entry storage with one write port and one registered read port
module sst_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [sst_pkg::IDX_W-1:0]      wr_addr,
  input  logic signed [sst_pkg::VAL_W-1:0] wr_data,
  input  logic [sst_pkg::IDX_W-1:0]      rd_addr,
  output logic signed [sst_pkg::VAL_W-1:0] rd_data
);

  logic signed [sst_pkg::VAL_W-1:0] mem [sst_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/sst_cmp.sv
// shared compare unit: equality and order test of one entry against the probe
module sst_cmp (
  input  logic signed [sst_pkg::VAL_W-1:0] entry,
  input  logic signed [sst_pkg::VAL_W-1:0] probe,
  input  logic                             descending,
  output sst_pkg::cmp_res_t                res
);

  always_comb begin
    res.eq    = (entry == probe);
    res.ahead = descending ? (entry >= probe) : (entry <= probe);
  end

endmodule

### rtl/core/sorted_set_table.sv
// sorted set table top level: sequencer over the entry ram and compare unit
//
//  channel | signals                          | dir | moves
//  --------+----------------------------------+-----+-------------------------
//  in      | in_valid in_ready operation value| in  | one add/remove/search request
//  out     | out_valid out_ready status count | out | one result per request
//          | empty_res                        |     |
//  cfg     | cfg_valid cfg_ready cfg_data     | in  | descending order bit
//
// a request scans the held entries one by one through the single ram read
// port, moves entries on add or remove and places an added value, then waits
// in the result state until out_ready.
// in_ready is high only in idle; one request is in flight at a time.
// rst is synchronous active high and empties the set; cfg_ready is always high.
module sorted_set_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sst_pkg::OP_W-1:0]            operation,
  input  logic signed [sst_pkg::VAL_W-1:0]    value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sst_pkg::STAT_W-1:0]          status,
  output logic [sst_pkg::COUNT_W-1:0]         count,
  output logic                                empty_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data
);

  localparam int CNT_W = sst_pkg::CNT_W;
  localparam int IDX_W = sst_pkg::IDX_W;

  sst_pkg::state_t state, state_next;

  logic [sst_pkg::OP_W-1:0]         op;
  logic signed [sst_pkg::VAL_W-1:0] probe;
  logic [CNT_W-1:0]                 cnt;
  logic [CNT_W-1:0]                 idx;
  logic [CNT_W-1:0]                 ipos;
  logic [CNT_W-1:0]                 fpos;
  logic                             found;
  logic                             stopped;
  logic [sst_pkg::STAT_W-1:0]       res_status;
  logic                             descending;

  logic                             wr_en;
  logic [IDX_W-1:0]                 wr_addr;
  logic signed [sst_pkg::VAL_W-1:0] wr_data;
  logic [CNT_W-1:0]                 rd_idx;
  logic signed [sst_pkg::VAL_W-1:0] rd_data;
  sst_pkg::cmp_res_t                cmp;

  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;
  logic             is_add;

  assign idx_inc = idx + CNT_W'(1);
  assign idx_dec = idx - CNT_W'(1);
  assign is_add  = (op == sst_pkg::OP_ADD);

  sst_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  sst_cmp u_cmp (
    .entry      (rd_data),
    .probe      (probe),
    .descending (descending),
    .res        (cmp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sst_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (cnt == '0) ? sst_pkg::ST_DECIDE : sst_pkg::ST_SCAN_RD;
        end
      end
      sst_pkg::ST_SCAN_RD: state_next = sst_pkg::ST_SCAN_CMP;
      sst_pkg::ST_SCAN_CMP: begin
        state_next = (idx_inc == cnt) ? sst_pkg::ST_DECIDE : sst_pkg::ST_SCAN_RD;
      end
      sst_pkg::ST_DECIDE: begin
        case (op)
          sst_pkg::OP_ADD: begin
            if (found || cnt >= CNT_W'(sst_pkg::CAPACITY)) begin
              state_next = sst_pkg::ST_RESP;
            end else if (ipos == cnt) begin
              state_next = sst_pkg::ST_PUT;
            end else begin
              state_next = sst_pkg::ST_SHIFT_RD;
            end
          end
          sst_pkg::OP_REMOVE: begin
            if (found && (fpos + CNT_W'(1)) < cnt) begin
              state_next = sst_pkg::ST_SHIFT_RD;
            end else begin
              state_next = sst_pkg::ST_RESP;
            end
          end
          default: state_next = sst_pkg::ST_RESP;
        endcase
      end
      sst_pkg::ST_SHIFT_RD: state_next = sst_pkg::ST_SHIFT_WR;
      sst_pkg::ST_SHIFT_WR: begin
        if (is_add) begin
          state_next = (idx_dec == ipos) ? sst_pkg::ST_PUT : sst_pkg::ST_SHIFT_RD;
        end else begin
          state_next = ((idx + CNT_W'(2)) == cnt) ? sst_pkg::ST_RESP
                                                  : sst_pkg::ST_SHIFT_RD;
        end
      end
      sst_pkg::ST_PUT: state_next = sst_pkg::ST_RESP;
      sst_pkg::ST_RESP: begin
        if (out_ready) begin
          state_next = sst_pkg::ST_IDLE;
        end
      end
      default: state_next = sst_pkg::ST_IDLE;
    endcase
  end

  // handshake and ram controls
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx[IDX_W-1:0];
    wr_data   = rd_data;
    rd_idx    = idx;
    case (state)
      sst_pkg::ST_IDLE:     in_ready = 1'b1;
      sst_pkg::ST_SHIFT_RD: rd_idx = is_add ? idx_dec : idx_inc;
      sst_pkg::ST_SHIFT_WR: wr_en = 1'b1;
      sst_pkg::ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = ipos[IDX_W-1:0];
        wr_data = probe;
      end
      sst_pkg::ST_RESP:     out_valid = 1'b1;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign status    = res_status;
  assign count     = sst_pkg::COUNT_W'(cnt);
  assign empty_res = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sst_pkg::ST_IDLE;
      cnt        <= '0;
      descending <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        descending <= cfg_data;
      end
      case (state)
        sst_pkg::ST_IDLE: begin
          if (in_valid) begin
            idx <= '0;
          end
        end
        sst_pkg::ST_SCAN_CMP: idx <= idx_inc;
        sst_pkg::ST_DECIDE: begin
          case (op)
            sst_pkg::OP_ADD: begin
              idx <= cnt;
              if (found) begin
                res_status <= sst_pkg::STAT_MISS;
              end else if (cnt >= CNT_W'(sst_pkg::CAPACITY)) begin
                res_status <= sst_pkg::STAT_FULL;
              end
            end
            sst_pkg::OP_REMOVE: begin
              idx <= fpos;
              if (found) begin
                res_status <= sst_pkg::STAT_OK;
                if ((fpos + CNT_W'(1)) >= cnt) begin
                  cnt <= cnt - CNT_W'(1);
                end
              end else begin
                res_status <= sst_pkg::STAT_MISS;
              end
            end
            sst_pkg::OP_SEARCH: begin
              res_status <= found ? sst_pkg::STAT_OK : sst_pkg::STAT_MISS;
            end
            default: res_status <= sst_pkg::STAT_MISS;
          endcase
        end
        sst_pkg::ST_SHIFT_WR: begin
          if (is_add) begin
            idx <= idx_dec;
          end else begin
            idx <= idx_inc;
            if ((idx + CNT_W'(2)) == cnt) begin
              cnt <= cnt - CNT_W'(1);
            end
          end
        end
        sst_pkg::ST_PUT: begin
          cnt        <= cnt + CNT_W'(1);
          res_status <= sst_pkg::STAT_OK;
        end
        default: ;
      endcase
    end
  end

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    case (state)
      sst_pkg::ST_IDLE: begin
        if (in_valid) begin
          op      <= operation;
          probe   <= value;
          ipos    <= cnt;
          fpos    <= '0;
          found   <= 1'b0;
          stopped <= 1'b0;
        end
      end
      sst_pkg::ST_SCAN_CMP: begin
        if (cmp.eq && !found) begin
          found <= 1'b1;
          fpos  <= idx;
        end
        if (!cmp.ahead && !stopped) begin
          stopped <= 1'b1;
          ipos    <= idx;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(sst_pkg::CAPACITY))
    else $error("held count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sst_pkg::STAT_FULL |-> cnt == CNT_W'(sst_pkg::CAPACITY))
    else $error("full status with free room");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(cnt) |->
      (cnt == $past(cnt) + CNT_W'(1)) || (cnt + CNT_W'(1) == $past(cnt)))
    else $error("held count moved by more than one");

  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !in_ready && !out_valid)
    else $error("ram written outside of a request");

endmodule

### sim/tb_sorted_set_table.sv
// testbench for sorted_set_table: random and directed requests checked against a sorted-set predictor
module tb_sorted_set_table;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } set_result_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] value;
  logic                    out_valid;
  logic                    out_ready;
  logic [STAT_W-1:0]       status;
  logic [COUNT_W-1:0]      count;
  logic                    empty_res;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic                    cfg_data;

  logic signed [VAL_W-1:0] held_vals [CAPACITY];
  int                      held_size;
  logic                    desc_order;

  set_result_t due_results[$];
  int          error_count;
  int          cycle_count;
  bit          gap_enable;
  bit          stall_enable;

  sorted_set_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count     (count),
    .empty_res (empty_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sorted_set_table] ERROR");
      $finish;
    end
  end

  function automatic bit precedes(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
    return desc_order ? (a >= b) : (a <= b);
  endfunction

  function automatic set_result_t apply_request(logic [OP_W-1:0] op,
                                                logic signed [VAL_W-1:0] v);
    set_result_t r;
    int          hit;
    int          pos;
    hit = -1;
    for (int i = held_size - 1; i >= 0; i--) begin
      if (held_vals[i] == v) hit = i;
    end
    r.status = STAT_MISS;
    case (op)
      OP_ADD: begin
        if (hit >= 0) begin
          r.status = STAT_MISS;
        end else if (held_size >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          pos = 0;
          while (pos < held_size && precedes(held_vals[pos], v)) pos++;
          for (int i = held_size; i > pos; i--) held_vals[i] = held_vals[i-1];
          held_vals[pos] = v;
          held_size++;
          r.status = STAT_OK;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < held_size; i++) held_vals[i] = held_vals[i+1];
          held_size--;
          r.status = STAT_OK;
        end
      end
      OP_SEARCH: begin
        r.status = (hit >= 0) ? STAT_OK : STAT_MISS;
      end
      default: r.status = STAT_MISS;
    endcase
    r.count     = held_size[COUNT_W-1:0];
    r.empty_res = (held_size == 0);
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    set_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result with no request pending: status %0d count %0d empty %0d",
               status, count, empty_res);
        error_count++;
      end else begin
        want = due_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count);
          error_count++;
        end
        if (empty_res !== want.empty_res) begin
          $error("empty_res: expected %0d, got %0d", want.empty_res, empty_res);
          error_count++;
        end
      end
    end
  end

  // result side: random stall, when enabled, ahead of every result
  initial begin : drain_results
    int stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = stall_enable ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v);
    int gap;
    gap = gap_enable ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(apply_request(op, v));
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (due_results.size() != 0);
  endtask

  task automatic write_sort_order(logic d);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    desc_order = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35 && held_size > 0) return held_vals[$urandom_range(0, held_size - 1)];
    if (sel < 75) return $signed($urandom_range(0, 24)) - 12;
    if (sel < 80) return VAL_MIN + $urandom_range(0, 3);
    if (sel < 85) return VAL_MAX - $urandom_range(0, 3);
    return $urandom;
  endfunction

  task automatic run_random(int n, int add_pct, int rem_pct);
    int              r;
    logic [OP_W-1:0] op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) op = OP_ADD;
      else if (r < add_pct + rem_pct) op = OP_REMOVE;
      else if (r < 98) op = OP_SEARCH;
      else op = OP_UNUSED;
      send_request(op, pick_value());
    end
  endtask

  task automatic test_empty_set();
    send_request(OP_SEARCH, 0);
    send_request(OP_REMOVE, VAL_MIN);
    send_request(OP_UNUSED, VAL_MAX);
  endtask

  task automatic test_value_extremes();
    send_request(OP_ADD, VAL_MAX);
    send_request(OP_ADD, VAL_MIN);
    send_request(OP_ADD, 0);
    send_request(OP_ADD, -1);
    send_request(OP_ADD, VAL_MAX);
    send_request(OP_SEARCH, VAL_MIN);
    send_request(OP_REMOVE, 0);
    send_request(OP_REMOVE, 32'sh5555_aaaa);
    send_request(OP_UNUSED, -1);
  endtask

  task automatic test_fill_to_capacity();
    for (int k = 1; k <= 13; k++) send_request(OP_ADD, k * 32'sh0111_1111);
    send_request(OP_ADD, 32'sh2aaa_5555);
    send_request(OP_ADD, -1);
  endtask

  task automatic test_order_switch_held();
    write_sort_order(1'b1);
    run_random(60, 15, 60);
    run_random(120, 65, 15);
    write_sort_order(1'b0);
    run_random(120, 45, 35);
  endtask

  task automatic test_drain_pause();
    run_random(20, 50, 30);
    wait_all_results();
    run_random(20, 50, 30);
  endtask

  task automatic test_random_mix();
    write_sort_order(1'b1);
    run_random(200, 70, 15);
    run_random(150, 30, 50);
    write_sort_order(1'b0);
    run_random(200, 55, 30);
  endtask

  task automatic test_no_idle();
    gap_enable   = 1'b0;
    stall_enable = 1'b0;
    run_random(100, 50, 30);
    write_sort_order(1'b1);
    run_random(100, 60, 25);
    gap_enable   = 1'b1;
    stall_enable = 1'b1;
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    operation    = OP_ADD;
    value        = '0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    held_size    = 0;
    desc_order   = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    gap_enable   = 1'b1;
    stall_enable = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_set();
    test_value_extremes();
    test_fill_to_capacity();
    test_order_switch_held();
    test_drain_pause();
    test_random_mix();
    test_no_idle();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("[sorted_set_table] OK");
    end else begin
      $display("[sorted_set_table] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/sst_pkg.sv
rtl/core/sst_ram.sv
rtl/core/sst_cmp.sv
rtl/core/sorted_set_table.sv
sim/tb_sorted_set_table.sv
